FILE: rtl/nggp_pkg.sv
// shared types, character codes and constants of the gga position parser
package nggp_pkg;

  // ascii codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // comma field numbers
  localparam logic [3:0] FLD_LAT      = 4'd2;
  localparam logic [3:0] FLD_LAT_HEMI = 4'd3;
  localparam logic [3:0] FLD_LON      = 4'd4;
  localparam logic [3:0] FLD_LON_HEMI = 4'd5;
  localparam logic [3:0] FLD_FIX      = 4'd6;
  localparam logic [3:0] FLD_SATS     = 4'd7;
  localparam logic [3:0] FLD_ALT      = 4'd9;
  localparam logic [3:0] FLD_LAST     = 4'd15;

  // header positions of "GGA" inside the sentence
  localparam logic [7:0] HDR_POS0 = 8'd2;
  localparam logic [7:0] HDR_POS1 = 8'd3;
  localparam logic [7:0] HDR_POS2 = 8'd4;
  localparam logic [2:0] HDR_ALL  = 3'b111;

  // seen bits of the pending values
  localparam int unsigned SEEN_LAT      = 0;
  localparam int unsigned SEEN_LAT_HEMI = 1;
  localparam int unsigned SEEN_LON      = 2;
  localparam int unsigned SEEN_LON_HEMI = 3;
  localparam int unsigned SEEN_FIX      = 4;
  localparam int unsigned SEEN_SATS     = 5;
  localparam int unsigned SEEN_ALT      = 6;

  // saturation limits
  localparam logic [23:0] ALT_CAP     = 24'd8388608;
  localparam logic [23:0] ALT_POS_MAX = 24'd8388607;
  localparam logic [19:0] MIN_CAP     = 20'd599999;
  localparam logic [10:0] LON_DEG_CAP = 11'd180;
  localparam logic [23:0] BYTE_MAX    = 24'd255;

  // angle scaling: deg * 10^7 + floor(m * 50 / 3), the divide by 3 done as
  // a multiply by 50 * (2^25 + 1) / 3 and a shift by 25, exact for 50m < 2^25
  localparam logic [23:0] DEG_SCALE = 24'd10000000;
  localparam logic [29:0] MIN_RECIP = 30'd559240550;
  localparam int unsigned MIN_SHIFT = 25;

  typedef struct packed {
    logic        commit;
    logic        in_sent;
    logic [6:0]  seen;
    logic [1:0]  neg;
    logic [7:0]  fix;
    logic [7:0]  sats;
    logic [23:0] alt;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [7:0]  lat_deg;
    logic [19:0] lat_min;
    logic [7:0]  lon_deg;
    logic [19:0] lon_min;
  } commit_t;

  // minute digit weight for a character position, latitude DDMM.mmmm
  function automatic logic [16:0] lat_min_weight(input logic [3:0] p);
    logic [16:0] w;
    unique case (p)
      4'd2:    w = 17'd100000;
      4'd3:    w = 17'd10000;
      4'd5:    w = 17'd1000;
      4'd6:    w = 17'd100;
      4'd7:    w = 17'd10;
      4'd8:    w = 17'd1;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

  // minute digit weight for a character position, longitude DDDMM.mmmm
  function automatic logic [16:0] lon_min_weight(input logic [3:0] p);
    logic [16:0] w;
    unique case (p)
      4'd3:    w = 17'd100000;
      4'd4:    w = 17'd10000;
      4'd6:    w = 17'd1000;
      4'd7:    w = 17'd100;
      4'd8:    w = 17'd10;
      4'd9:    w = 17'd1;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/nggp_angle.sv
// two-stage fixed point angle conversion, degrees and minutes to 1e-7 degree
module nggp_angle (
  input  logic        clk,
  input  logic        en_mul,
  input  logic        en_add,
  input  logic [7:0]  deg,
  input  logic [19:0] min,
  output logic [30:0] angle
);
  import nggp_pkg::*;

  logic [31:0] deg_prod;
  logic [49:0] min_prod;
  logic [30:0] deg_part;
  logic [23:0] min_part;

  assign deg_prod = 32'(deg) * 32'(DEG_SCALE);
  assign min_prod = 50'(min) * 50'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (en_mul) begin
      deg_part <= deg_prod[30:0];
      min_part <= min_prod[MIN_SHIFT +: 24];
    end
    if (en_add) begin
      angle <= deg_part + 31'(min_part);
    end
  end

endmodule

FILE: rtl/nggp_parse.sv
// sentence framing, field splitting and digit accumulation, one byte per cycle while load is high
module nggp_parse #(
  parameter int unsigned MAX_LEN = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [7:0]        rx_byte,
  output nggp_pkg::commit_t snap
);
  import nggp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  logic          started, started_next;
  logic [CW-1:0] char_count, char_count_next;
  logic [3:0]    field_index, field_index_next;
  logic [3:0]    pos, pos_next;
  logic [2:0]    hdr, hdr_next;
  logic [7:0]    deg, deg_next;
  logic [19:0]   min, min_next;
  logic [23:0]   dec, dec_next;
  logic          digit_stop, digit_stop_next;
  logic          neg, neg_next;

  // pending values of the open sentence
  logic [6:0]  seen, seen_next;
  logic [1:0]  pneg, pneg_next;
  logic [7:0]  p_lat_deg, p_lat_deg_next;
  logic [19:0] p_lat_min, p_lat_min_next;
  logic [7:0]  p_lon_deg, p_lon_deg_next;
  logic [19:0] p_lon_min, p_lon_min_next;
  logic [7:0]  p_fix, p_fix_next;
  logic [7:0]  p_sats, p_sats_next;
  logic [23:0] p_alt, p_alt_next;

  // pending values with the current field closed
  logic [6:0]  f_seen;
  logic [1:0]  f_neg;
  logic [7:0]  f_lat_deg, f_lon_deg, f_fix, f_sats;
  logic [19:0] f_lat_min, f_lon_min;
  logic [23:0] f_alt;

  logic        isdig;
  logic [3:0]  d;
  logic [7:0]  lat_deg_add;
  logic [10:0] lon_deg_add, lon_deg_sum;
  logic [16:0] min_w;
  logic [20:0] min_add;
  logic [26:0] dec_sum;
  logic [19:0] min_capped;
  logic [7:0]  dec_byte;
  logic [23:0] alt_val;
  logic        commit_now;

  assign isdig = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign d     = isdig ? 4'(rx_byte - CH_ZERO) : 4'd0;

  // digit feed terms
  always_comb begin
    unique case (pos)
      4'd0:    lat_deg_add = {1'b0, d, 3'b000} + {3'b000, d, 1'b0};
      4'd1:    lat_deg_add = {4'b0000, d};
      default: lat_deg_add = 8'd0;
    endcase
    unique case (pos)
      4'd0:    lon_deg_add = 11'(d) * 11'd100;
      4'd1:    lon_deg_add = 11'(d) * 11'd10;
      4'd2:    lon_deg_add = 11'(d);
      default: lon_deg_add = 11'd0;
    endcase
    lon_deg_sum = 11'(deg) + lon_deg_add;
    min_w   = (field_index == FLD_LON) ? lon_min_weight(pos) : lat_min_weight(pos);
    min_add = 21'(d) * 21'(min_w);
    dec_sum = {dec, 3'b000} + {2'b00, dec, 1'b0} + 27'(d);
  end

  // closing the current field
  always_comb begin
    min_capped = (min > MIN_CAP) ? MIN_CAP : min;
    dec_byte   = (dec > BYTE_MAX) ? 8'hff : dec[7:0];
    if (neg) begin
      alt_val = 24'd0 - ((dec > ALT_CAP) ? ALT_CAP : dec);
    end else begin
      alt_val = (dec > ALT_POS_MAX) ? ALT_POS_MAX : dec;
    end

    f_seen    = seen;
    f_neg     = pneg;
    f_lat_deg = p_lat_deg;
    f_lat_min = p_lat_min;
    f_lon_deg = p_lon_deg;
    f_lon_min = p_lon_min;
    f_fix     = p_fix;
    f_sats    = p_sats;
    f_alt     = p_alt;
    if (pos != 4'd0) begin
      unique case (field_index)
        FLD_LAT: begin
          f_lat_deg = deg;
          f_lat_min = min_capped;
          f_seen[SEEN_LAT] = 1'b1;
        end
        FLD_LAT_HEMI: begin
          f_seen[SEEN_LAT_HEMI] = 1'b1;
          if (neg) f_neg[0] = 1'b1;
        end
        FLD_LON: begin
          f_lon_deg = deg;
          f_lon_min = min_capped;
          f_seen[SEEN_LON] = 1'b1;
        end
        FLD_LON_HEMI: begin
          f_seen[SEEN_LON_HEMI] = 1'b1;
          if (neg) f_neg[1] = 1'b1;
        end
        FLD_FIX: begin
          f_fix = dec_byte;
          f_seen[SEEN_FIX] = 1'b1;
        end
        FLD_SATS: begin
          f_sats = dec_byte;
          f_seen[SEEN_SATS] = 1'b1;
        end
        FLD_ALT: begin
          f_alt = alt_val;
          f_seen[SEEN_ALT] = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // byte handling
  always_comb begin
    started_next     = started;
    char_count_next  = char_count;
    field_index_next = field_index;
    pos_next         = pos;
    hdr_next         = hdr;
    deg_next         = deg;
    min_next         = min;
    dec_next         = dec;
    digit_stop_next  = digit_stop;
    neg_next         = neg;
    seen_next        = seen;
    pneg_next        = pneg;
    p_lat_deg_next   = p_lat_deg;
    p_lat_min_next   = p_lat_min;
    p_lon_deg_next   = p_lon_deg;
    p_lon_min_next   = p_lon_min;
    p_fix_next       = p_fix;
    p_sats_next      = p_sats;
    p_alt_next       = p_alt;
    commit_now       = 1'b0;

    priority if (rx_byte == CH_DOLLAR || (rx_byte == CH_CR && started)) begin
      // start or end: both clear the sentence
      commit_now       = (rx_byte == CH_CR) && (hdr == HDR_ALL);
      started_next     = (rx_byte == CH_DOLLAR);
      char_count_next  = '0;
      field_index_next = 4'd0;
      hdr_next         = 3'd0;
      seen_next        = 7'd0;
      pneg_next        = 2'd0;
      pos_next         = 4'd0;
      deg_next         = 8'd0;
      min_next         = 20'd0;
      dec_next         = 24'd0;
      digit_stop_next  = 1'b0;
      neg_next         = 1'b0;
    end else if (started && char_count < CW'(MAX_LEN)) begin
      if (char_count == CW'(HDR_POS0) && rx_byte == CH_G) hdr_next[0] = 1'b1;
      if (char_count == CW'(HDR_POS1) && rx_byte == CH_G) hdr_next[1] = 1'b1;
      if (char_count == CW'(HDR_POS2) && rx_byte == CH_A) hdr_next[2] = 1'b1;
      char_count_next = char_count + 1'b1;
      if (rx_byte == CH_COMMA) begin
        seen_next      = f_seen;
        pneg_next      = f_neg;
        p_lat_deg_next = f_lat_deg;
        p_lat_min_next = f_lat_min;
        p_lon_deg_next = f_lon_deg;
        p_lon_min_next = f_lon_min;
        p_fix_next     = f_fix;
        p_sats_next    = f_sats;
        p_alt_next     = f_alt;
        if (field_index != FLD_LAST) field_index_next = field_index + 4'd1;
        pos_next        = 4'd0;
        deg_next        = 8'd0;
        min_next        = 20'd0;
        dec_next        = 24'd0;
        digit_stop_next = 1'b0;
        neg_next        = 1'b0;
      end else begin
        unique case (field_index)
          FLD_LAT: begin
            deg_next = deg + lat_deg_add;
            min_next = min + min_add[19:0];
          end
          FLD_LON: begin
            deg_next = (lon_deg_sum > LON_DEG_CAP) ? LON_DEG_CAP[7:0] : lon_deg_sum[7:0];
            min_next = min + min_add[19:0];
          end
          FLD_LAT_HEMI, FLD_LON_HEMI: begin
            if (pos == 4'd0 && (rx_byte == CH_S || rx_byte == CH_W)) neg_next = 1'b1;
          end
          FLD_FIX, FLD_SATS, FLD_ALT: begin
            if (pos == 4'd0 && field_index == FLD_ALT &&
                (rx_byte == CH_MINUS || rx_byte == CH_PLUS)) begin
              neg_next = (rx_byte == CH_MINUS);
            end else if (!digit_stop) begin
              if (isdig) begin
                dec_next = (dec_sum > 27'(ALT_CAP)) ? ALT_CAP : dec_sum[23:0];
              end else begin
                digit_stop_next = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        if (pos != 4'd15) pos_next = pos + 4'd1;
      end
    end else begin
      // idle byte or past the length limit
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      char_count  <= '0;
      field_index <= 4'd0;
      pos         <= 4'd0;
      hdr         <= 3'd0;
      digit_stop  <= 1'b0;
      neg         <= 1'b0;
      seen        <= 7'd0;
      pneg        <= 2'd0;
    end else if (load) begin
      started     <= started_next;
      char_count  <= char_count_next;
      field_index <= field_index_next;
      pos         <= pos_next;
      hdr         <= hdr_next;
      digit_stop  <= digit_stop_next;
      neg         <= neg_next;
      seen        <= seen_next;
      pneg        <= pneg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      deg       <= deg_next;
      min       <= min_next;
      dec       <= dec_next;
      p_lat_deg <= p_lat_deg_next;
      p_lat_min <= p_lat_min_next;
      p_lon_deg <= p_lon_deg_next;
      p_lon_min <= p_lon_min_next;
      p_fix     <= p_fix_next;
      p_sats    <= p_sats_next;
      p_alt     <= p_alt_next;
      snap.side.commit  <= commit_now;
      snap.side.in_sent <= started_next;
      snap.side.seen    <= f_seen;
      snap.side.neg     <= f_neg;
      snap.side.fix     <= f_fix;
      snap.side.sats    <= f_sats;
      snap.side.alt     <= f_alt;
      snap.lat_deg      <= f_lat_deg;
      snap.lat_min      <= f_lat_min;
      snap.lon_deg      <= f_lon_deg;
      snap.lon_min      <= f_lon_min;
    end
  end

endmodule

FILE: rtl/nmea_gga_position_parser.sv
// nmea gga position parser: byte pipeline, angle conversion and committed outputs
// a byte passes the input, parser, multiply, add and result registers in turn before out_valid shows it
// throughput: one byte per cycle while out_stall is low, set by the parser update in stage two
// a stalled output holds the full stages; bubbles in front of them still fill
// reset: pipeline empty, no sentence open, all committed values read as zero
module nmea_gga_position_parser #(
  parameter int unsigned MAX_SENTENCE_LEN = 128
) (
  input  logic        clk,
  input  logic        rst,
  // byte request
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // result request
  output logic        out_valid,
  input  logic        out_stall,
  output logic        committed,
  output logic        in_sentence,
  output logic [29:0] lat_magnitude,
  output logic signed [30:0] lat_signed,
  output logic [30:0] lon_magnitude,
  output logic signed [31:0] lon_signed,
  output logic [7:0]  fix_quality,
  output logic [7:0]  satellites,
  output logic signed [23:0] altitude
);
  import nggp_pkg::*;

  // stage valids: 1 input byte, 2 parser, 3 multiply, 4 add, 5 result
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;
  logic [7:0] s1_byte;

  commit_t s2_snap;
  side_t   s3_side, s4_side;
  logic [30:0] lat_angle, lon_angle;

  // committed value registers
  logic [29:0] lat_mag_reg;
  logic [30:0] lat_reg;
  logic [30:0] lon_mag_reg;
  logic [31:0] lon_reg;
  logic [7:0]  fix_reg, sats_reg;
  logic [23:0] alt_reg;
  logic        committed_reg, in_sent_reg;

  logic [29:0] lat_mag_new;
  logic [30:0] lon_mag_new;

  // a stage takes new data when it is empty or its content moves on
  assign s5_rdy = !s5_valid || !out_stall;
  assign s4_rdy = !s4_valid || s5_rdy;
  assign s3_rdy = !s3_valid || s4_rdy;
  assign s2_rdy = !s2_valid || s3_rdy;
  assign s1_rdy = !s1_valid || s2_rdy;

  assign in_stall = !s1_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (s1_rdy) s1_valid <= in_valid;
      if (s2_rdy) s2_valid <= s1_valid;
      if (s3_rdy) s3_valid <= s2_valid;
      if (s4_rdy) s4_valid <= s3_valid;
      if (s5_rdy) s5_valid <= s4_valid;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) s1_byte <= rx_byte;
  end

  // parser state advances once per byte leaving stage one
  nggp_parse #(
    .MAX_LEN (MAX_SENTENCE_LEN)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .load    (s1_valid && s2_rdy),
    .rx_byte (s1_byte),
    .snap    (s2_snap)
  );

  // angle conversion over stages three and four
  nggp_angle u_lat_angle (
    .clk    (clk),
    .en_mul (s2_valid && s3_rdy),
    .en_add (s3_valid && s4_rdy),
    .deg    (s2_snap.lat_deg),
    .min    (s2_snap.lat_min),
    .angle  (lat_angle)
  );

  nggp_angle u_lon_angle (
    .clk    (clk),
    .en_mul (s2_valid && s3_rdy),
    .en_add (s3_valid && s4_rdy),
    .deg    (s2_snap.lon_deg),
    .min    (s2_snap.lon_min),
    .angle  (lon_angle)
  );

  // the remaining fields ride alongside the angle stages
  always_ff @(posedge clk) begin
    if (s2_valid && s3_rdy) s3_side <= s2_snap.side;
    if (s3_valid && s4_rdy) s4_side <= s3_side;
  end

  // sign follows the freshly committed magnitude, or the old one if no position came
  assign lat_mag_new = s4_side.seen[SEEN_LAT] ? lat_angle[29:0] : lat_mag_reg;
  assign lon_mag_new = s4_side.seen[SEEN_LON] ? lon_angle : lon_mag_reg;

  // result stage: committed registers update in byte order
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_mag_reg   <= 30'd0;
      lat_reg       <= 31'd0;
      lon_mag_reg   <= 31'd0;
      lon_reg       <= 32'd0;
      fix_reg       <= 8'd0;
      sats_reg      <= 8'd0;
      alt_reg       <= 24'd0;
      committed_reg <= 1'b0;
      in_sent_reg   <= 1'b0;
    end else if (s4_valid && s5_rdy) begin
      committed_reg <= s4_side.commit;
      in_sent_reg   <= s4_side.in_sent;
      if (s4_side.commit) begin
        lat_mag_reg <= lat_mag_new;
        lon_mag_reg <= lon_mag_new;
        if (s4_side.seen[SEEN_LAT_HEMI]) begin
          lat_reg <= s4_side.neg[0] ? 31'd0 - {1'b0, lat_mag_new} : {1'b0, lat_mag_new};
        end
        if (s4_side.seen[SEEN_LON_HEMI]) begin
          lon_reg <= s4_side.neg[1] ? 32'd0 - {1'b0, lon_mag_new} : {1'b0, lon_mag_new};
        end
        if (s4_side.seen[SEEN_FIX])  fix_reg  <= s4_side.fix;
        if (s4_side.seen[SEEN_SATS]) sats_reg <= s4_side.sats;
        if (s4_side.seen[SEEN_ALT])  alt_reg  <= s4_side.alt;
      end
    end
  end

  assign out_valid     = s5_valid;
  assign committed     = committed_reg;
  assign in_sentence   = in_sent_reg;
  assign lat_magnitude = lat_mag_reg;
  assign lat_signed    = lat_reg;
  assign lon_magnitude = lon_mag_reg;
  assign lon_signed    = lon_reg;
  assign fix_quality   = fix_reg;
  assign satellites    = sats_reg;
  assign altitude      = alt_reg;

  // a commit always closes the sentence
  a_commit_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && committed |-> !in_sentence)
    else $error("commit reported with a sentence still open");

  // converted angles stay inside their ranges
  a_lat_range: assert property (@(posedge clk) disable iff (rst)
    lat_magnitude <= 30'd999999983)
    else $error("latitude magnitude out of range");

  a_lon_range: assert property (@(posedge clk) disable iff (rst)
    lon_magnitude <= 31'd1809999983)
    else $error("longitude magnitude out of range");

  // an accepted byte is held in the input stage on the next cycle
  a_byte_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted byte lost at the input stage");

endmodule
